// ===== sv/lde_pkg.sv =====
// ----------------------------------------------------------------------------
// lde_pkg - shared definitions for the launch detect and eject controller
// Holds the sequencer states, the phase codes, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package lde_pkg;

    // Default number of samples in the averaging window.
    localparam int WINDOW_LEN_DEF = 10;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_LAUNCH_THR  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LATERAL_THR = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_EJECT_THR = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EMERGENCY   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_EJECT_DELAY = 3'd4;

    // Reset values of the configuration registers.
    localparam logic signed [15:0] LAUNCH_THR_RST  = -16'sd2304;
    localparam logic        [14:0] LATERAL_THR_RST = 15'd2048;
    localparam logic signed [15:0] Z_EJECT_THR_RST = -16'sd2304;
    localparam logic        [15:0] EMERGENCY_RST   = 16'd10000;
    localparam logic        [15:0] EJECT_DELAY_RST = 16'd2000;

    // Flight phase codes as reported on the result channel.
    localparam logic [1:0] PHASE_WAIT      = 2'd0;
    localparam logic [1:0] PHASE_LAUNCHED  = 2'd1;
    localparam logic [1:0] PHASE_NORMAL    = 2'd2;
    localparam logic [1:0] PHASE_EMERGENCY = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SQR,
        ST_DECIDE
    } lde_state_t;

endpackage

// ===== sv/lde_ram.sv =====
// ----------------------------------------------------------------------------
// lde_ram - generic single write port RAM with one registered read port
// Write and read may use different addresses in the same cycle.
// ----------------------------------------------------------------------------
module lde_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 10
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/launch_detect_eject_controller.sv =====
// ----------------------------------------------------------------------------
// launch_detect_eject_controller - launch detection and eject decision
// Averages the last WINDOW_LEN acceleration samples, detects launch from the
// average z and decides a normal or emergency eject, then halts.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  --------------------------------
//  s_        in         s_valid / s_ready    accel_x, accel_y, accel_z, time_ms
//  m_        out        m_valid / m_ready    phase, eject_fire, avg_x/y/z
//  cfg_      in         cfg_wr_en only       cfg_addr, cfg_wdata
//
// For a request, the window sum walks the sample RAM one entry per cycle,
// then the single shared multiplier does three reciprocal divides and
// three squares, one per cycle, followed by the decision state.
// Once halted, a request is answered in the cycle after it is accepted.
// Reset (aresetn, synchronous) clears the control state, the window valid
// bits and the configuration registers; the RAM itself is not cleared.
// A result that is not taken holds the sequencer in its decision state;
// a new request is still accepted while the previous result waits, unless halted.
// ----------------------------------------------------------------------------
module launch_detect_eject_controller #(
    parameter int WINDOW_LEN = lde_pkg::WINDOW_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_accel_x,
    input  logic signed [15:0]            s_accel_y,
    input  logic signed [15:0]            s_accel_z,
    input  logic        [31:0]            s_time_ms,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [1:0]             m_phase,
    output logic                          m_eject_fire,
    output logic signed [15:0]            m_avg_x,
    output logic signed [15:0]            m_avg_y,
    output logic signed [15:0]            m_avg_z,

    input  logic                          cfg_wr_en,
    input  logic [lde_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]                   cfg_wdata
);

    // ------------------------------------------------------------------
    // Derived sizes.
    // ------------------------------------------------------------------
    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int LOG_N  = $clog2(WINDOW_LEN);
    // Window sum width; its magnitude also fits in this many unsigned bits.
    localparam int SUM_W  = 16 + LOG_N;
    // Divide by WINDOW_LEN as floor(mag * DIV_MUL / 2^DIV_SH). With the
    // extra LOG_N shift bits the rounding error never reaches one unit.
    localparam int DIV_SH = SUM_W + LOG_N;
    localparam logic [63:0] DIV_MUL =
        ((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam int MUL_W  = SUM_W + 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MAG_W  = 17;
    localparam int LAT_W  = 33;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(WINDOW_LEN);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [15:0] launch_thr_reg;
    logic        [14:0] lateral_thr_reg;
    logic signed [15:0] z_eject_thr_reg;
    logic        [15:0] emergency_reg;
    logic        [15:0] eject_delay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_thr_reg  <= lde_pkg::LAUNCH_THR_RST;
            lateral_thr_reg <= lde_pkg::LATERAL_THR_RST;
            z_eject_thr_reg <= lde_pkg::Z_EJECT_THR_RST;
            emergency_reg   <= lde_pkg::EMERGENCY_RST;
            eject_delay_reg <= lde_pkg::EJECT_DELAY_RST;
        end else if (cfg_wr_en) begin
            // Indexes beyond the register list fall through and are ignored.
            priority case (cfg_addr)
                lde_pkg::REG_LAUNCH_THR:  launch_thr_reg  <= cfg_wdata;
                lde_pkg::REG_LATERAL_THR: lateral_thr_reg <= cfg_wdata[14:0];
                lde_pkg::REG_Z_EJECT_THR: z_eject_thr_reg <= cfg_wdata;
                lde_pkg::REG_EMERGENCY:   emergency_reg   <= cfg_wdata;
                lde_pkg::REG_EJECT_DELAY: eject_delay_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State.
    // ------------------------------------------------------------------
    lde_pkg::lde_state_t state_reg, state_next;

    logic [WINDOW_LEN-1:0]     ring_vld_reg, ring_vld_next;
    logic [IDX_W-1:0]          slot_reg, slot_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [1:0]                step_reg, step_next;
    logic                      rd_pend_reg, rd_pend_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      launched_reg, launched_next;
    logic [31:0]               launch_time_reg, launch_time_next;
    logic [1:0]                final_phase_reg, final_phase_next;
    logic [31:0]               time_reg, time_next;
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [MAG_W-1:0]          mag_next [3];
    logic signed [15:0]        avg_reg [3];
    logic signed [15:0]        avg_next [3];
    logic [LAT_W-1:0]          lat2_reg, lat2_next;
    logic [31:0]               thr2_reg, thr2_next;

    logic                      m_valid_reg, m_valid_next;
    logic [1:0]                m_phase_reg, m_phase_next;
    logic                      m_fire_reg, m_fire_next;
    logic signed [15:0]        m_avg_reg [3];
    logic signed [15:0]        m_avg_next [3];

    // Sample RAM, one entry of {z, y, x} per window slot.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [47:0]       ram_rdata;

    lde_ram #(
        .WIDTH (48),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({s_accel_z, s_accel_y, s_accel_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: reciprocal divides, then squares.
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum_mag;
    logic              sum_neg;
    logic [MAG_W-1:0]  quot;

    assign prod = mul_a * mul_b;

    always_comb begin
        sum_neg = sum_reg[step_reg][SUM_W-1];
        sum_mag = sum_neg ? SUM_W'(-sum_reg[step_reg]) : SUM_W'(sum_reg[step_reg]);
        quot    = prod[DIV_SH +: MAG_W];
        mul_a   = '0;
        mul_b   = '0;
        if (state_reg == lde_pkg::ST_DIV) begin
            mul_a = MUL_W'(sum_mag);
            mul_b = DIV_MUL[MUL_W-1:0];
        end else if (step_reg == 2'd2) begin
            mul_a = MUL_W'(lateral_thr_reg);
            mul_b = MUL_W'(lateral_thr_reg);
        end else begin
            mul_a = MUL_W'(mag_reg[step_reg]);
            mul_b = MUL_W'(mag_reg[step_reg]);
        end
    end

    // ------------------------------------------------------------------
    // Decision logic on the finished averages.
    // ------------------------------------------------------------------
    logic        launch_now;
    logic        launched_eff;
    logic [31:0] base_time;
    logic [31:0] elapsed;
    logic        emergency_hit;
    logic        normal_hit;
    logic        out_free;
    logic        halted;
    logic        accept;

    assign halted   = (final_phase_reg != lde_pkg::PHASE_WAIT);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == lde_pkg::ST_IDLE) && (!halted || out_free);
    assign accept   = s_valid && s_ready;

    always_comb begin
        launch_now    = !launched_reg && (avg_reg[2] <= launch_thr_reg);
        launched_eff  = launched_reg || launch_now;
        base_time     = launch_now ? time_reg : launch_time_reg;
        elapsed       = time_reg - base_time;
        emergency_hit = launched_eff && (elapsed > {16'd0, emergency_reg});
        normal_hit    = launched_eff && (elapsed > {16'd0, eject_delay_reg}) &&
                        ((lat2_reg >= LAT_W'(thr2_reg)) || (avg_reg[2] < z_eject_thr_reg));
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates.
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        ring_vld_next    = ring_vld_reg;
        slot_next        = slot_reg;
        cnt_next         = cnt_reg;
        step_next        = step_reg;
        rd_pend_next     = 1'b0;
        rd_vld_next      = 1'b0;
        launched_next    = launched_reg;
        launch_time_next = launch_time_reg;
        final_phase_next = final_phase_reg;
        time_next        = time_reg;
        sum_next         = sum_reg;
        mag_next         = mag_reg;
        avg_next         = avg_reg;
        lat2_next        = lat2_reg;
        thr2_next        = thr2_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_phase_next     = m_phase_reg;
        m_fire_next      = m_fire_reg;
        m_avg_next       = m_avg_reg;
        ram_we           = 1'b0;
        ram_raddr        = '0;

        unique case (state_reg)
            lde_pkg::ST_IDLE: begin
                if (accept) begin
                    if (halted) begin
                        // A halted block answers with its final phase only.
                        m_valid_next = 1'b1;
                        m_phase_next = final_phase_reg;
                        m_fire_next  = 1'b0;
                        m_avg_next   = '{default: '0};
                    end else begin
                        ram_we                  = 1'b1;
                        ring_vld_next[slot_reg] = 1'b1;
                        slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                        time_next  = s_time_ms;
                        sum_next   = '{default: '0};
                        cnt_next   = '0;
                        state_next = lde_pkg::ST_SUM;
                    end
                end
            end

            lde_pkg::ST_SUM: begin
                // Issue one read per cycle and add the entry read last cycle.
                if (cnt_reg != CNT_END) begin
                    ram_raddr    = cnt_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_vld_next  = ring_vld_reg[cnt_reg[IDX_W-1:0]];
                    cnt_next     = cnt_reg + 1'b1;
                end else begin
                    step_next  = 2'd0;
                    state_next = lde_pkg::ST_DIV;
                end
                if (rd_pend_reg && rd_vld_reg) begin
                    sum_next[0] = sum_reg[0] + SUM_W'(signed'(ram_rdata[15:0]));
                    sum_next[1] = sum_reg[1] + SUM_W'(signed'(ram_rdata[31:16]));
                    sum_next[2] = sum_reg[2] + SUM_W'(signed'(ram_rdata[47:32]));
                end
            end

            lde_pkg::ST_DIV: begin
                mag_next[step_reg] = quot;
                avg_next[step_reg] = sum_neg ? -signed'(quot[15:0]) : signed'(quot[15:0]);
                if (step_reg == 2'd2) begin
                    step_next  = 2'd0;
                    state_next = lde_pkg::ST_SQR;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            lde_pkg::ST_SQR: begin
                unique case (step_reg)
                    2'd0: lat2_next = LAT_W'(prod);
                    2'd1: lat2_next = lat2_reg + LAT_W'(prod);
                    default: thr2_next = prod[31:0];
                endcase
                if (step_reg == 2'd2) begin
                    state_next = lde_pkg::ST_DECIDE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            lde_pkg::ST_DECIDE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_avg_next   = avg_reg;
                    m_fire_next  = emergency_hit || normal_hit;
                    if (launch_now) begin
                        launched_next    = 1'b1;
                        launch_time_next = time_reg;
                    end
                    // The emergency timeout takes precedence over a normal eject.
                    priority if (emergency_hit) begin
                        m_phase_next     = lde_pkg::PHASE_EMERGENCY;
                        final_phase_next = lde_pkg::PHASE_EMERGENCY;
                    end else if (normal_hit) begin
                        m_phase_next     = lde_pkg::PHASE_NORMAL;
                        final_phase_next = lde_pkg::PHASE_NORMAL;
                    end else if (launched_eff) begin
                        m_phase_next = lde_pkg::PHASE_LAUNCHED;
                    end else begin
                        m_phase_next = lde_pkg::PHASE_WAIT;
                    end
                    state_next = lde_pkg::ST_IDLE;
                end
            end

            default: state_next = lde_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lde_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg    <= '0;
            slot_reg        <= '0;
            cnt_reg         <= '0;
            step_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            launched_reg    <= 1'b0;
            launch_time_reg <= '0;
            final_phase_reg <= lde_pkg::PHASE_WAIT;
            m_valid_reg     <= 1'b0;
        end else begin
            ring_vld_reg    <= ring_vld_next;
            slot_reg        <= slot_next;
            cnt_reg         <= cnt_next;
            step_reg        <= step_next;
            rd_pend_reg     <= rd_pend_next;
            launched_reg    <= launched_next;
            launch_time_reg <= launch_time_next;
            final_phase_reg <= final_phase_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        rd_vld_reg  <= rd_vld_next;
        time_reg    <= time_next;
        sum_reg     <= sum_next;
        mag_reg     <= mag_next;
        avg_reg     <= avg_next;
        lat2_reg    <= lat2_next;
        thr2_reg    <= thr2_next;
        m_phase_reg <= m_phase_next;
        m_fire_reg  <= m_fire_next;
        m_avg_reg   <= m_avg_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_phase      = m_phase_reg;
    assign m_eject_fire = m_fire_reg;
    assign m_avg_x      = m_avg_reg[0];
    assign m_avg_y      = m_avg_reg[1];
    assign m_avg_z      = m_avg_reg[2];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Once halted, the final phase never changes.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted |=> final_phase_reg == $past(final_phase_reg))
        else $error("final phase changed after halt");

    // A fired eject always reports one of the two eject phases.
    a_fire_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_eject_fire) |->
        (m_phase == lde_pkg::PHASE_NORMAL || m_phase == lde_pkg::PHASE_EMERGENCY))
        else $error("eject fired without an eject phase");

    // Loading a fired result halts the block in the same cycle.
    a_fire_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_eject_fire && !$past(m_valid && m_eject_fire)) |-> halted)
        else $error("eject fired but block not halted");

    // Results from a halted block carry zero averages.
    a_halted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_eject_fire &&
         (m_phase == lde_pkg::PHASE_NORMAL || m_phase == lde_pkg::PHASE_EMERGENCY)) |->
        (m_avg_x == 16'sd0 && m_avg_y == 16'sd0 && m_avg_z == 16'sd0))
        else $error("halted result with nonzero averages");

endmodule
